// ===== rtl/swmam_pkg.sv =====
package swmam_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // Configuration port.
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    localparam int REG_IDX_W = APB_AW - 2;

    // Register map, one 32-bit register per word.
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b0;

    localparam int                CFG_W     = 7;
    localparam logic [CFG_W-1:0]  CFG_RESET = 7'd4;

    // Fraction bits of the mean.
    localparam int FRAC_BITS = 8;

endpackage

// ===== rtl/swmam_ram.sv =====
module swmam_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/swmam_div.sv =====
module swmam_div #(
    parameter int DW = 30,
    parameter int VW = 7
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    q_reg, q_next;
    logic [VW-1:0]    rem_reg, rem_next;
    logic [VW-1:0]    dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [VW:0] rem_sh;
    logic [VW:0] diff;

    // Restoring division, one quotient bit per cycle. The dividend shifts out
    // of the top of q_reg while quotient bits shift in at the bottom.
    always_comb begin
        rem_sh    = {rem_reg, q_reg[DW-1]};
        diff      = rem_sh - {1'b0, dvs_reg};
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, dvs_reg}) begin
                rem_next = diff[VW-1:0];
                q_next   = {q_reg[DW-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[VW-1:0];
                q_next   = {q_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== rtl/sliding_window_min_avg_max.sv =====
// One item at a time: the ring memory is read once a cycle over the older window entries,
// then the bit-serial divider shifts out DW quotient bits, where DW = SAMPLE_BITS +
// log2(MAX_WINDOW) + 8 (30 by default); a new beat is taken only once the result is
// registered and the FSM is back in idle, which a stalled result side holds off.
// Reset (synchronous, active low) empties the ring logically and sets window_size to 4.
module sliding_window_min_avg_max #(
    parameter int MAX_WINDOW  = swmam_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = swmam_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // APB configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [swmam_pkg::APB_AW-1:0]         paddr,
    input  logic [swmam_pkg::APB_DW-1:0]         pwdata,
    output logic [swmam_pkg::APB_DW-1:0]         prdata,
    output logic                                 pready,
    // Input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    // Result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata: sample_echo, window_min, window_max, window_mean
    output logic [((4*SAMPLE_BITS+15)/8)*8-1:0]  m_axis_tdata
);

    import swmam_pkg::*;

    localparam int AW       = $clog2(MAX_WINDOW);
    localparam int WSW      = $clog2(MAX_WINDOW + 1);
    localparam int CW       = (WSW > CFG_W) ? WSW : CFG_W;
    localparam int SUM_W    = SAMPLE_BITS + AW;
    localparam int DW       = SUM_W + FRAC_BITS;
    localparam int MEAN_W   = SAMPLE_BITS + FRAC_BITS;
    localparam int M_TDATA_W = ((4*SAMPLE_BITS+15)/8)*8;

    localparam int STW = 2;
    localparam logic [STW-1:0] ST_IDLE = 2'd0;
    localparam logic [STW-1:0] ST_SCAN = 2'd1;
    localparam logic [STW-1:0] ST_DIV  = 2'd2;
    localparam logic [STW-1:0] ST_OUT  = 2'd3;

    logic [STW-1:0]              state_reg, state_next;
    logic [CFG_W-1:0]            cfg_reg, cfg_next;
    logic [AW-1:0]               wp_reg, wp_next;
    logic [AW-1:0]               rp_reg, rp_next;
    logic [WSW-1:0]              fill_reg, fill_next;
    logic signed [SAMPLE_BITS-1:0] first_reg, first_next;
    logic [WSW-1:0]              issue_reg, issue_next;
    logic                        rdv_reg, rdv_next;
    logic [AW-1:0]               rdidx_reg, rdidx_next;
    logic [WSW-1:0]              ws_reg, ws_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic signed [SAMPLE_BITS-1:0] min_reg, min_next;
    logic signed [SAMPLE_BITS-1:0] max_reg, max_next;
    logic signed [SUM_W-1:0]     sum_reg, sum_next;
    logic                        mvalid_reg, mvalid_next;
    logic [M_TDATA_W-1:0]        mdata_reg, mdata_next;

    logic                          s_accept;
    logic                          cfg_sel;
    logic                          cfg_we;
    logic signed [SAMPLE_BITS-1:0] s_sample;
    logic [CW-1:0]                 cfg_ext;
    logic [WSW-1:0]                ws_eff;
    logic                          ram_re;
    logic [SAMPLE_BITS-1:0]        ram_q;
    logic signed [SAMPLE_BITS-1:0] rd_val;
    logic                          div_start;
    logic                          div_done;
    logic [DW-1:0]                 quotient;
    logic [SUM_W-1:0]              sum_mag;
    logic [DW-1:0]                 q_signed;
    logic signed [MEAN_W-1:0]      mean;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[APB_AW-1:2] == REG_WINDOW_SIZE);
    assign cfg_we  = psel && penable && pwrite && pready && cfg_sel;
    assign prdata  = cfg_sel ? APB_DW'(cfg_reg) : '0;
    assign cfg_next = cfg_we ? pwdata[CFG_W-1:0] : cfg_reg;

    // A window of zero counts as one, anything above the ring depth as the full ring.
    assign cfg_ext = CW'(cfg_reg);
    always_comb begin
        if (cfg_ext == '0) begin
            ws_eff = WSW'(1);
        end else if (cfg_ext > CW'(MAX_WINDOW)) begin
            ws_eff = WSW'(MAX_WINDOW);
        end else begin
            ws_eff = cfg_ext[WSW-1:0];
        end
    end

    assign s_sample      = s_axis_tdata[SAMPLE_BITS-1:0];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Entries from the first sample onwards are written in ring order, so any
    // entry at or above the fill count is not written yet and reads as the first sample.
    assign rd_val = (WSW'(rdidx_reg) < fill_reg) ? ram_q : first_reg;

    assign div_start = (state_reg == ST_SCAN) && (issue_reg == '0) && !rdv_reg;
    assign sum_mag   = sum_reg[SUM_W-1] ? (-sum_reg) : sum_reg;
    assign q_signed  = sum_reg[SUM_W-1] ? (-quotient) : quotient;
    // The mean never exceeds the sample range scaled by 256, so it always fits.
    assign mean      = q_signed[MEAN_W-1:0];

    always_comb begin
        state_next  = state_reg;
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        fill_next   = fill_reg;
        first_next  = first_reg;
        issue_next  = issue_reg;
        rdv_next    = 1'b0;
        rdidx_next  = rdidx_reg;
        ws_next     = ws_reg;
        sample_next = sample_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        sum_next    = sum_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        ram_re      = 1'b0;

        if (mvalid_reg && m_axis_tready) begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    sample_next = s_sample;
                    min_next    = s_sample;
                    max_next    = s_sample;
                    sum_next    = SUM_W'(s_sample);
                    ws_next     = ws_eff;
                    issue_next  = ws_eff - 1'b1;
                    wp_next     = (wp_reg == AW'(MAX_WINDOW - 1)) ? '0 : wp_reg + 1'b1;
                    rp_next     = (wp_reg == '0) ? AW'(MAX_WINDOW - 1) : wp_reg - 1'b1;
                    if (fill_reg == '0) begin
                        first_next = s_sample;
                        fill_next  = WSW'(1);
                    end else if (fill_reg != WSW'(MAX_WINDOW)) begin
                        fill_next = fill_reg + 1'b1;
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Older entries only: the new sample is already in the running values.
                if (issue_reg != '0) begin
                    ram_re     = 1'b1;
                    rdv_next   = 1'b1;
                    rdidx_next = rp_reg;
                    rp_next    = (rp_reg == '0) ? AW'(MAX_WINDOW - 1) : rp_reg - 1'b1;
                    issue_next = issue_reg - 1'b1;
                end
                if (rdv_reg) begin
                    if (rd_val < min_reg) begin
                        min_next = rd_val;
                    end
                    if (rd_val > max_reg) begin
                        max_next = rd_val;
                    end
                    sum_next = sum_reg + SUM_W'(rd_val);
                end
                if (div_start) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!mvalid_reg || m_axis_tready) begin
                    mvalid_next = 1'b1;
                    mdata_next  = M_TDATA_W'({mean, max_reg, min_reg, sample_reg});
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cfg_reg    <= CFG_RESET;
            wp_reg     <= '0;
            rp_reg     <= '0;
            fill_reg   <= '0;
            issue_reg  <= '0;
            rdv_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cfg_reg    <= cfg_next;
            wp_reg     <= wp_next;
            rp_reg     <= rp_next;
            fill_reg   <= fill_next;
            issue_reg  <= issue_next;
            rdv_reg    <= rdv_next;
            mvalid_reg <= mvalid_next;
        end
        first_reg  <= first_next;
        rdidx_reg  <= rdidx_next;
        ws_reg     <= ws_next;
        sample_reg <= sample_next;
        min_reg    <= min_next;
        max_reg    <= max_next;
        sum_reg    <= sum_next;
        mdata_reg  <= mdata_next;
    end

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = mdata_reg;

    swmam_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .aclk  (aclk),
        .we    (s_accept),
        .waddr (wp_reg),
        .wdata (s_sample),
        .re    (ram_re),
        .raddr (rp_reg),
        .rdata (ram_q)
    );

    swmam_div #(
        .DW (DW),
        .VW (WSW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({sum_mag, {FRAC_BITS{1'b0}}}),
        .divisor  (ws_reg),
        .done     (div_done),
        .quotient (quotient)
    );

endmodule

// ===== rtl/swmam_chk.sv =====
module swmam_chk #(
    parameter int MAX_WINDOW  = swmam_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = swmam_pkg::SAMPLE_BITS_DEF
) (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 psel,
    input logic                                 penable,
    input logic                                 pwrite,
    input logic [swmam_pkg::APB_AW-1:0]         paddr,
    input logic [swmam_pkg::APB_DW-1:0]         pwdata,
    input logic [swmam_pkg::APB_DW-1:0]         prdata,
    input logic                                 pready,
    input logic                                 s_axis_tvalid,
    input logic                                 s_axis_tready,
    // tdata: sample
    input logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    // tdata: sample_echo, window_min, window_max, window_mean
    input logic [((4*SAMPLE_BITS+15)/8)*8-1:0]  m_axis_tdata
);

    import swmam_pkg::*;

    localparam int MEAN_W = SAMPLE_BITS + FRAC_BITS;

    logic signed [SAMPLE_BITS-1:0] echo;
    logic signed [SAMPLE_BITS-1:0] wmin;
    logic signed [SAMPLE_BITS-1:0] wmax;
    logic signed [MEAN_W-1:0]      wmean;
    logic signed [MEAN_W-1:0]      min_scaled;
    logic signed [MEAN_W-1:0]      max_scaled;

    assign echo       = m_axis_tdata[SAMPLE_BITS-1:0];
    assign wmin       = m_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign wmax       = m_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
    assign wmean      = m_axis_tdata[3*SAMPLE_BITS+MEAN_W-1:3*SAMPLE_BITS];
    assign min_scaled = $signed({wmin, {FRAC_BITS{1'b0}}});
    assign max_scaled = $signed({wmax, {FRAC_BITS{1'b0}}});

    // A result beat that is held back keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // Only one sample is worked on at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a sample is in progress");

    // The newest sample lies inside its own window.
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (wmin <= echo) && (echo <= wmax))
        else $error("sample outside window minimum and maximum");

    // A truncated mean stays between the scaled extremes.
    a_mean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (wmean >= min_scaled) && (wmean <= max_scaled))
        else $error("window mean outside window range");

endmodule

bind sliding_window_min_avg_max swmam_chk #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_swmam_chk (.*);
